### design/sed_pkg.sv
// Shared types, error codes and helper functions for the string escape decoder.
`timescale 1ns / 1ps
`default_nettype none
package sed_pkg;

  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;

  localparam logic [3:0] ERR_NONE      = 4'd0;
  localparam logic [3:0] ERR_UNKNOWN   = 4'd1;
  localparam logic [3:0] ERR_UNIVERSAL = 4'd2;
  localparam logic [3:0] ERR_NO_HEX    = 4'd3;
  localparam logic [3:0] ERR_EMPTY     = 4'd4;
  localparam logic [3:0] ERR_BAD_DIGIT = 4'd5;
  localparam logic [3:0] ERR_NO_BRACE  = 4'd6;
  localparam logic [3:0] ERR_CUT_OFF   = 4'd7;
  localparam logic [3:0] ERR_OCTAL_O   = 4'd8;

  localparam logic [7:0] CODE_BEL = 8'd7;
  localparam logic [7:0] CODE_BS  = 8'd8;
  localparam logic [7:0] CODE_HT  = 8'd9;
  localparam logic [7:0] CODE_LF  = 8'd10;
  localparam logic [7:0] CODE_VT  = 8'd11;
  localparam logic [7:0] CODE_FF  = 8'd12;
  localparam logic [7:0] CODE_CR  = 8'd13;
  localparam logic [7:0] CODE_ESC = 8'd27;

  typedef struct packed {
    logic [7:0] value;
    logic       has_byte;
    logic [3:0] error_code;
    logic       literal_end;
    logic       run_last;
  } res_t;

  typedef struct packed {
    res_t       r0;
    res_t       r1;
    logic [1:0] cnt;
  } pend_t;

  typedef struct packed {
    res_t r0;
    res_t r1;
    logic two;
  } entry_t;

  function automatic pend_t push(pend_t p, logic [7:0] v, logic has, logic [3:0] err);
    res_t  r;
    pend_t q;
    q             = p;
    r.value       = has ? v : 8'd0;
    r.has_byte    = has;
    r.error_code  = err;
    r.literal_end = 1'b0;
    r.run_last    = 1'b0;
    if (p.cnt == 2'd0) begin
      q.r0  = r;
      q.cnt = 2'd1;
    end else if (p.cnt == 2'd1) begin
      q.r1  = r;
      q.cnt = 2'd2;
    end
    return q;
  endfunction

  // {valid, digit value}
  function automatic logic [4:0] hex_digit(logic [7:0] c);
    logic [7:0] d;
    logic [4:0] h;
    d = 8'd0;
    h = 5'd0;
    if (c >= "0" && c <= "9") begin
      d = c - "0";
      h = {1'b1, d[3:0]};
    end else if (c >= "a" && c <= "f") begin
      d = c - "a" + 8'd10;
      h = {1'b1, d[3:0]};
    end else if (c >= "A" && c <= "F") begin
      d = c - "A" + 8'd10;
      h = {1'b1, d[3:0]};
    end
    return h;
  endfunction

endpackage
`default_nettype wire

### design/sed_front.sv
// Front end: accepts characters, tracks escape state and forms result transactions.
`timescale 1ns / 1ps
`default_nettype none
module sed_front import sed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  input  wire logic       q_full,
  output logic            q_push,
  output entry_t          q_entry
);

  typedef enum logic [7:0] {
    M_NORMAL    = 8'b0000_0001,
    M_ESC       = 8'b0000_0010,
    M_HEX_FIRST = 8'b0000_0100,
    M_HEX_RUN   = 8'b0000_1000,
    M_HEX_DELIM = 8'b0001_0000,
    M_OCT       = 8'b0010_0000,
    M_OCT_O     = 8'b0100_0000,
    M_DROP      = 8'b1000_0000
  } mode_t;

  mode_t      mode_r, mode_nxt;
  logic [7:0] acc_r, acc_nxt;
  logic [1:0] cnt_r, cnt_nxt;
  pend_t      p;
  logic [4:0] hx;
  logic       oct_d;
  logic       accept;

  assign in_stall = q_full;
  assign accept   = in_valid && !in_stall;

  always_comb begin
    mode_nxt = mode_r;
    acc_nxt  = acc_r;
    cnt_nxt  = cnt_r;
    p        = '0;
    hx       = hex_digit(in_ch);
    oct_d    = in_ch inside {["0":"7"]};

    case (mode_r)
      M_ESC: begin
        mode_nxt = M_NORMAL;
        case (in_ch)
          "(", "{", "[", "%", "\\", "'", "\"", "?": p = push(p, in_ch, 1'b1, ERR_NONE);
          "a":      p = push(p, CODE_BEL, 1'b1, ERR_NONE);
          "b":      p = push(p, CODE_BS, 1'b1, ERR_NONE);
          "t":      p = push(p, CODE_HT, 1'b1, ERR_NONE);
          "n":      p = push(p, CODE_LF, 1'b1, ERR_NONE);
          "v":      p = push(p, CODE_VT, 1'b1, ERR_NONE);
          "f":      p = push(p, CODE_FF, 1'b1, ERR_NONE);
          "r":      p = push(p, CODE_CR, 1'b1, ERR_NONE);
          "e", "E": p = push(p, CODE_ESC, 1'b1, ERR_NONE);
          "u", "U", "N": begin
            p        = push(p, 8'd0, 1'b0, ERR_UNIVERSAL);
            mode_nxt = M_DROP;
          end
          "x": begin
            acc_nxt  = 8'd0;
            mode_nxt = M_HEX_FIRST;
          end
          "o": mode_nxt = M_OCT_O;
          default: begin
            if (oct_d) begin
              acc_nxt  = {5'd0, in_ch[2:0]};
              cnt_nxt  = 2'd1;
              mode_nxt = M_OCT;
            end else begin
              p = push(p, in_ch, 1'b1, ERR_UNKNOWN);
            end
          end
        endcase
      end
      M_HEX_FIRST: begin
        if (in_ch == "{") begin
          cnt_nxt  = 2'd0;
          mode_nxt = M_HEX_DELIM;
        end else if (hx[4]) begin
          acc_nxt  = {4'd0, hx[3:0]};
          mode_nxt = M_HEX_RUN;
        end else begin
          mode_nxt = M_NORMAL;
          p        = push(p, in_ch, 1'b1, ERR_NO_HEX);
        end
      end
      M_HEX_RUN: begin
        if (hx[4]) begin
          acc_nxt = {acc_r[3:0], hx[3:0]};
        end else begin
          p        = push(p, acc_r, 1'b1, ERR_NONE);
          mode_nxt = M_NORMAL;
          if (in_ch == "\\") mode_nxt = M_ESC;
          else p = push(p, in_ch, 1'b1, ERR_NONE);
        end
      end
      M_HEX_DELIM: begin
        if (in_ch == "}") begin
          p        = push(p, acc_r, 1'b1, (cnt_r != 2'd0) ? ERR_NONE : ERR_EMPTY);
          mode_nxt = M_NORMAL;
        end else begin
          cnt_nxt = 2'd1;
          if (hx[4]) acc_nxt = {acc_r[3:0], hx[3:0]};
          else p = push(p, 8'd0, 1'b0, ERR_BAD_DIGIT);
        end
      end
      M_OCT: begin
        if (oct_d && cnt_r != 2'd3) begin
          acc_nxt = {acc_r[4:0], in_ch[2:0]};
          cnt_nxt = cnt_r + 2'd1;
          if (cnt_nxt == 2'd3) begin
            p        = push(p, acc_nxt, 1'b1, ERR_NONE);
            mode_nxt = M_NORMAL;
          end
        end else begin
          p        = push(p, acc_r, 1'b1, ERR_NONE);
          mode_nxt = M_NORMAL;
          if (in_ch == "\\") mode_nxt = M_ESC;
          else p = push(p, in_ch, 1'b1, ERR_NONE);
        end
      end
      M_OCT_O: begin
        mode_nxt = M_NORMAL;
        p        = push(p, in_ch, 1'b1, ERR_OCTAL_O);
      end
      M_DROP: begin
      end
      default: begin
        mode_nxt = M_NORMAL;
        if (in_ch == "\\") mode_nxt = M_ESC;
        else p = push(p, in_ch, 1'b1, ERR_NONE);
      end
    endcase

    if (in_last) begin
      case (mode_nxt)
        M_ESC, M_HEX_FIRST, M_OCT_O: p = push(p, 8'd0, 1'b0, ERR_CUT_OFF);
        M_HEX_RUN, M_OCT:            p = push(p, acc_nxt, 1'b1, ERR_NONE);
        M_HEX_DELIM:                 p = push(p, acc_nxt, 1'b1, ERR_NO_BRACE);
        default: begin
        end
      endcase
      if (p.cnt == 2'd0) p = push(p, 8'd0, 1'b0, ERR_NONE);
      if (p.cnt == 2'd2) p.r1.literal_end = 1'b1;
      else p.r0.literal_end = 1'b1;
      mode_nxt = M_NORMAL;
      acc_nxt  = 8'd0;
      cnt_nxt  = 2'd0;
    end

    if (p.cnt == 2'd2) p.r1.run_last = 1'b1;
    else if (p.cnt == 2'd1) p.r0.run_last = 1'b1;
  end

  assign q_push        = accept && (p.cnt != 2'd0);
  assign q_entry.r0    = p.r0;
  assign q_entry.r1    = p.r1;
  assign q_entry.two   = (p.cnt == 2'd2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= M_NORMAL;
      acc_r  <= 8'd0;
      cnt_r  <= 2'd0;
    end else if (accept) begin
      mode_r <= mode_nxt;
      acc_r  <= acc_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### design/sed_queue.sv
// Short queue of result transactions between the front and back ends.
`timescale 1ns / 1ps
`default_nettype none
module sed_queue import sed_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   push_en,
  input  wire entry_t push_entry,
  output logic        full,
  output logic        not_empty,
  input  wire logic   pop_en,
  output entry_t      head
);

  entry_t                mem_r [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0]   wr_ptr_r, rd_ptr_r;
  logic [QUEUE_AW:0]     count_r;

  assign full      = (count_r == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign not_empty = (count_r != '0);
  assign head      = mem_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_en) mem_r[wr_ptr_r] <= push_entry;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push_en) begin
        wr_ptr_r <= (wr_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (pop_en) begin
        rd_ptr_r <= (rd_ptr_r == QUEUE_AW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      if (push_en && !pop_en) count_r <= count_r + 1'b1;
      else if (pop_en && !push_en) count_r <= count_r - 1'b1;
    end
  end

endmodule
`default_nettype wire

### design/sed_back.sv
// Back end: drains queued transactions and presents one result per cycle while out_stall is low.
`timescale 1ns / 1ps
`default_nettype none
module sed_back import sed_pkg::*; (
  input  wire logic   clk,
  input  wire logic   rst_n,
  input  wire logic   q_not_empty,
  input  wire entry_t q_head,
  output logic        q_pop,
  output logic        out_valid,
  input  wire logic   out_stall,
  output res_t        out_res
);

  logic out_valid_r, out_valid_nxt;
  logic hold2_r, hold2_nxt;
  res_t out_res_r, res2_r;
  logic load_ok;

  assign load_ok   = !out_valid_r || !out_stall;
  assign q_pop     = load_ok && !hold2_r && q_not_empty;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  always_comb begin
    out_valid_nxt = out_valid_r;
    hold2_nxt     = hold2_r;
    if (load_ok) begin
      if (hold2_r) begin
        out_valid_nxt = 1'b1;
        hold2_nxt     = 1'b0;
      end else begin
        out_valid_nxt = q_not_empty;
        hold2_nxt     = q_not_empty && q_head.two;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      hold2_r     <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
      hold2_r     <= hold2_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load_ok) begin
      if (hold2_r) begin
        out_res_r <= res2_r;
      end else if (q_not_empty) begin
        out_res_r <= q_head.r0;
        res2_r    <= q_head.r1;
      end
    end
  end

endmodule
`default_nettype wire

### design/string_escape_decoder.sv
// Top level of the string escape decoder: front end, queue and back end.
//
//  channel  direction  handshake           fields
//  in_      input      in_valid/in_stall   in_ch[7:0], in_last
//  out_     output     out_valid/out_stall out_value[7:0], out_has_byte,
//                                          out_error_code[3:0], out_literal_end,
//                                          out_run_last
//
// One character is taken per cycle while in_stall is low; it yields zero, one or two
// result transactions. The output register sends one result per cycle while out_stall is
// low; the two-entry queue absorbs items with two results, and the front end stalls only
// when the queue is full. Reset (rst_n low, synchronous) returns the decoder to plain
// text mode and empties the queue; no clearing pass is needed.
`timescale 1ns / 1ps
`default_nettype none
module string_escape_decoder import sed_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_ch,
  input  wire logic       in_last,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [7:0]      out_value,
  output logic            out_has_byte,
  output logic [3:0]      out_error_code,
  output logic            out_literal_end,
  output logic            out_run_last
);

  logic   q_full, q_push, q_not_empty, q_pop;
  entry_t q_entry, q_head;
  res_t   res;

  sed_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_ch    (in_ch),
    .in_last  (in_last),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_entry  (q_entry)
  );

  sed_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_en    (q_push),
    .push_entry (q_entry),
    .full       (q_full),
    .not_empty  (q_not_empty),
    .pop_en     (q_pop),
    .head       (q_head)
  );

  sed_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .q_not_empty (q_not_empty),
    .q_head      (q_head),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_res     (res)
  );

  assign out_value       = res.value;
  assign out_has_byte    = res.has_byte;
  assign out_error_code  = res.error_code;
  assign out_literal_end = res.literal_end;
  assign out_run_last    = res.run_last;

endmodule
`default_nettype wire

### tb/sv/string_escape_decoder_tb.sv
// Self-checking testbench for the string escape decoder: directed and random literals.
`timescale 1ns / 1ps
module string_escape_decoder_tb;
  import sed_pkg::*;

  typedef enum logic [2:0] {
    MD_PLAIN, MD_ESC, MD_HEX_FIRST, MD_HEX_RUN, MD_HEX_BRACE, MD_OCT, MD_OCT_O, MD_DROP
  } mode_e;

  typedef enum int {ST_NONE, ST_COIN, ST_EVERY_THIRD, ST_HEAVY} stall_e;

  typedef struct {
    logic [7:0] ch;
    logic       last;
    bit         drain;
  } stim_t;

  localparam int ITEM_TARGET  = 1100;
  localparam int DRAIN_EVERY  = 250;
  localparam int HOLD_AT      = 400;
  localparam int HOLD_CYCLES  = 150;
  localparam int TAIL_CYCLES  = 16;
  localparam int IDLE_LIMIT   = 2000;

  logic       clk;
  logic       rst_n    = 1'b0;
  logic       in_valid = 1'b0;
  logic [7:0] in_ch    = 8'd0;
  logic       in_last  = 1'b0;
  logic       out_stall = 1'b0;
  logic       in_stall;
  logic       out_valid;
  logic [7:0] out_value;
  logic       out_has_byte;
  logic [3:0] out_error_code;
  logic       out_literal_end;
  logic       out_run_last;

  string_escape_decoder DUT (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_ch          (in_ch),
    .in_last        (in_last),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_value      (out_value),
    .out_has_byte   (out_has_byte),
    .out_error_code (out_error_code),
    .out_literal_end(out_literal_end),
    .out_run_last   (out_run_last)
  );

  stim_t      stim_q[$];
  logic [7:0] lit_buf[$];
  res_t       predicted_results[$];
  res_t       step_res[2];
  int         step_n;
  mode_e      esc_mode   = MD_PLAIN;
  logic [7:0] esc_acc    = 8'd0;
  logic [1:0] esc_digits = 2'd0;
  res_t       got;
  res_t       want;
  int         error_count    = 0;
  int         accepted_items = 0;
  int         item_count     = 0;
  int         idle_cycles    = 0;
  logic       in_taken  = 1'b0;
  logic       hold_long = 1'b0;
  int         burst_left = 1;
  int         gap_left   = 0;
  int         stall_left = 0;
  stall_e     stall_kind = ST_NONE;
  logic       stall_now;
  string      simple_escapes = "({[%\\'\"?abtnvfreE";
  string      universal_escapes = "uUN";

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  initial begin
    repeat (8) @(negedge clk);
    rst_n <= 1'b1;
  end

  function automatic int hex_value(input logic [7:0] c);
    if (c >= "0" && c <= "9") return int'(c) - int'("0");
    if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
    if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
    return -1;
  endfunction

  task automatic add_result(input logic [7:0] v, input logic has, input logic [3:0] err);
    if (step_n < 2) begin
      step_res[step_n].value       = has ? v : 8'd0;
      step_res[step_n].has_byte    = has;
      step_res[step_n].error_code  = err;
      step_res[step_n].literal_end = 1'b0;
      step_res[step_n].run_last    = 1'b0;
      step_n++;
    end
  endtask

  task automatic plain_char(input logic [7:0] c);
    if (c == "\\") esc_mode = MD_ESC;
    else add_result(c, 1'b1, ERR_NONE);
  endtask

  task automatic escape_char(input logic [7:0] c);
    esc_mode = MD_PLAIN;
    case (c)
      "(", "{", "[", "%", "\\", "'", "\"", "?": add_result(c, 1'b1, ERR_NONE);
      "a": add_result(CODE_BEL, 1'b1, ERR_NONE);
      "b": add_result(CODE_BS, 1'b1, ERR_NONE);
      "t": add_result(CODE_HT, 1'b1, ERR_NONE);
      "n": add_result(CODE_LF, 1'b1, ERR_NONE);
      "v": add_result(CODE_VT, 1'b1, ERR_NONE);
      "f": add_result(CODE_FF, 1'b1, ERR_NONE);
      "r": add_result(CODE_CR, 1'b1, ERR_NONE);
      "e", "E": add_result(CODE_ESC, 1'b1, ERR_NONE);
      "u", "U", "N": begin
        add_result(8'd0, 1'b0, ERR_UNIVERSAL);
        esc_mode = MD_DROP;
      end
      "x": begin
        esc_acc  = 8'd0;
        esc_mode = MD_HEX_FIRST;
      end
      "o": esc_mode = MD_OCT_O;
      default: begin
        if (c >= "0" && c <= "7") begin
          esc_acc    = {5'd0, c[2:0]};
          esc_digits = 2'd1;
          esc_mode   = MD_OCT;
        end else begin
          add_result(c, 1'b1, ERR_UNKNOWN);
        end
      end
    endcase
  endtask

  task automatic decode_char(input logic [7:0] c, input logic is_last);
    int d;
    d      = hex_value(c);
    step_n = 0;
    case (esc_mode)
      MD_ESC: escape_char(c);
      MD_HEX_FIRST: begin
        if (c == "{") begin
          esc_digits = 2'd0;
          esc_mode   = MD_HEX_BRACE;
        end else if (d >= 0) begin
          esc_acc  = {4'd0, d[3:0]};
          esc_mode = MD_HEX_RUN;
        end else begin
          esc_mode = MD_PLAIN;
          add_result(c, 1'b1, ERR_NO_HEX);
        end
      end
      MD_HEX_RUN: begin
        if (d >= 0) begin
          esc_acc = {esc_acc[3:0], d[3:0]};
        end else begin
          add_result(esc_acc, 1'b1, ERR_NONE);
          esc_mode = MD_PLAIN;
          plain_char(c);
        end
      end
      MD_HEX_BRACE: begin
        if (c == "}") begin
          add_result(esc_acc, 1'b1, (esc_digits != 2'd0) ? ERR_NONE : ERR_EMPTY);
          esc_mode = MD_PLAIN;
        end else begin
          esc_digits = 2'd1;
          if (d >= 0) esc_acc = {esc_acc[3:0], d[3:0]};
          else add_result(8'd0, 1'b0, ERR_BAD_DIGIT);
        end
      end
      MD_OCT: begin
        if (c >= "0" && c <= "7" && esc_digits < 2'd3) begin
          esc_acc    = {esc_acc[4:0], c[2:0]};
          esc_digits = esc_digits + 2'd1;
          if (esc_digits == 2'd3) begin
            add_result(esc_acc, 1'b1, ERR_NONE);
            esc_mode = MD_PLAIN;
          end
        end else begin
          add_result(esc_acc, 1'b1, ERR_NONE);
          esc_mode = MD_PLAIN;
          plain_char(c);
        end
      end
      MD_OCT_O: begin
        esc_mode = MD_PLAIN;
        add_result(c, 1'b1, ERR_OCTAL_O);
      end
      MD_DROP: ;
      default: begin
        esc_mode = MD_PLAIN;
        plain_char(c);
      end
    endcase
    if (is_last) begin
      case (esc_mode)
        MD_ESC, MD_HEX_FIRST, MD_OCT_O: add_result(8'd0, 1'b0, ERR_CUT_OFF);
        MD_HEX_RUN, MD_OCT: add_result(esc_acc, 1'b1, ERR_NONE);
        MD_HEX_BRACE: add_result(esc_acc, 1'b1, ERR_NO_BRACE);
        default: ;
      endcase
      if (step_n == 0) add_result(8'd0, 1'b0, ERR_NONE);
      step_res[step_n - 1].literal_end = 1'b1;
      esc_mode   = MD_PLAIN;
      esc_acc    = 8'd0;
      esc_digits = 2'd0;
    end
    if (step_n > 0) step_res[step_n - 1].run_last = 1'b1;
    for (int i = 0; i < step_n; i++) predicted_results.push_back(step_res[i]);
  endtask

  task automatic put(input logic [7:0] c);
    lit_buf.push_back(c);
  endtask

  task automatic flush_literal();
    stim_t s;
    for (int i = 0; i < lit_buf.size(); i++) begin
      s.ch    = lit_buf[i];
      s.last  = (i == lit_buf.size() - 1);
      s.drain = 1'b0;
      stim_q.push_back(s);
    end
    item_count += lit_buf.size();
    lit_buf.delete();
  endtask

  task automatic add_text(input string s);
    for (int i = 0; i < s.len(); i++) put(s[i]);
    flush_literal();
  endtask

  task automatic add_drain();
    stim_t s;
    s.ch    = 8'd0;
    s.last  = 1'b0;
    s.drain = 1'b1;
    stim_q.push_back(s);
  endtask

  function automatic logic [7:0] hex_char();
    int d;
    d = $urandom_range(0, 15);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "a" : "A") + d - 10);
  endfunction

  task automatic random_literal();
    int  nseg;
    int  kind;
    int  n;
    bit  stop;
    nseg = $urandom_range(1, 6);
    stop = 1'b0;
    for (int s = 0; s < nseg && !stop; s++) begin
      kind = $urandom_range(0, 99);
      if (kind < 20) begin
        put(8'($urandom_range(0, 255)));
      end else if (kind < 40) begin
        put("\\");
        put(simple_escapes[$urandom_range(0, simple_escapes.len() - 1)]);
      end else if (kind < 55) begin
        put("\\");
        put("x");
        n = $urandom_range(1, 3);
        repeat (n) put(hex_char());
      end else if (kind < 67) begin
        put("\\");
        put("x");
        put("{");
        n = $urandom_range(0, 3);
        repeat (n) begin
          if ($urandom_range(0, 99) < 85) put(hex_char());
          else put(8'($urandom_range(0, 255)));
        end
        if ($urandom_range(0, 99) < 85) put("}");
      end else if (kind < 82) begin
        put("\\");
        n = $urandom_range(1, 4);
        repeat (n) put(8'("0" + $urandom_range(0, 7)));
      end else if (kind < 88) begin
        put("\\");
        put("o");
        put(8'($urandom_range(0, 255)));
      end else if (kind < 94) begin
        put("\\");
        put(8'($urandom_range(0, 255)));
      end else if (kind < 97) begin
        put("\\");
        case ($urandom_range(0, 2))
          1: put("x");
          2: put("o");
          default: ;
        endcase
        stop = 1'b1;
      end else begin
        put("\\");
        put(universal_escapes[$urandom_range(0, 2)]);
      end
    end
    flush_literal();
  endtask

  initial begin
    int next_drain;
    put(8'h00);
    put(8'hFF);
    flush_literal();
    add_text("\\q");
    add_text("\\x{}");
    add_text("\\xg");
    add_text("\\oz");
    add_text("\\uab");
    add_text("\\");
    add_text("\\x{4g");
    add_drain();
    next_drain = item_count + DRAIN_EVERY;
    while (item_count < ITEM_TARGET) begin
      random_literal();
      if (item_count >= next_drain) begin
        add_drain();
        next_drain += DRAIN_EVERY;
      end
    end
    wait (rst_n);
    while (stim_q.size() != 0 || in_valid) @(posedge clk);
    while (predicted_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (error_count == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

  // hold the receiver off long enough for the decoder to back up
  initial begin
    wait (accepted_items >= HOLD_AT);
    @(posedge clk);
    hold_long = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_long = 1'b0;
  end

  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      if (gap_left > 0) begin
        gap_left--;
        in_valid <= 1'b0;
      end else if (stim_q.size() == 0) begin
        in_valid <= 1'b0;
      end else if (stim_q[0].drain) begin
        in_valid <= 1'b0;
        if (predicted_results.size() == 0) void'(stim_q.pop_front());
      end else begin
        in_valid <= 1'b1;
        in_ch    <= stim_q[0].ch;
        in_last  <= stim_q[0].last;
        void'(stim_q.pop_front());
        if (burst_left > 1) begin
          burst_left--;
        end else begin
          burst_left = $urandom_range(1, 40);
          gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 6);
        end
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left == 0) begin
      stall_kind = stall_e'($urandom_range(0, 3));
      stall_left = $urandom_range(8, 64);
    end
    stall_left--;
    case (stall_kind)
      ST_NONE:        stall_now = 1'b0;
      ST_COIN:        stall_now = ($urandom_range(0, 1) == 0);
      ST_EVERY_THIRD: stall_now = (stall_left % 3 == 0);
      default:        stall_now = ($urandom_range(0, 9) < 8);
    endcase
    out_stall <= hold_long || stall_now;
  end

  task automatic note_failure(input string what);
    error_count++;
    if (error_count <= 10)
      $display("%0t %s: expected value=%02h has=%0b err=%0d end=%0b run_last=%0b, got value=%02h has=%0b err=%0d end=%0b run_last=%0b",
               $time, what, want.value, want.has_byte, want.error_code, want.literal_end,
               want.run_last, got.value, got.has_byte, got.error_code, got.literal_end,
               got.run_last);
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      in_taken = 1'b0;
    end else begin
      in_taken = in_valid && !in_stall;
      if (in_taken) begin
        decode_char(in_ch, in_last);
        accepted_items++;
      end
      if (out_valid && !out_stall) begin
        got.value       = out_value;
        got.has_byte    = out_has_byte;
        got.error_code  = out_error_code;
        got.literal_end = out_literal_end;
        got.run_last    = out_run_last;
        if (predicted_results.size() == 0) begin
          want = '0;
          note_failure("unexpected result");
        end else begin
          want = predicted_results.pop_front();
          if (got.value !== want.value || got.has_byte !== want.has_byte ||
              got.error_code !== want.error_code || got.literal_end !== want.literal_end ||
              got.run_last !== want.run_last)
            note_failure("result mismatch");
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout: no transaction for %0d cycles", IDLE_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

endmodule
